### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

### rtl/bld_pkg.sv
// ----------------------------------------------------------------------------
// bld_pkg
// Shared widths, command and status codes, and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bld_pkg;

	// Default sizing of the list
	localparam int DEF_CAPACITY      = 128;
	localparam int DEF_ELEMENT_WIDTH = 32;

	// Field widths on the stream ports
	localparam int CMD_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int POS_W      = 8;
	localparam int LEN_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 48;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_READ       = 3'd3,
		CMD_TAKE       = 3'd4,
		CMD_DROP       = 3'd5
	} cmd_t;

	// Status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-command outcome passed from control to the output pipeline
	typedef struct packed {
		logic [LEN_W-1:0] length;
		status_t          status;
		logic             rd_ok;
	} result_t;

endpackage

### rtl/bounded_list_deque_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_top
// Bounded deque over a circular element memory, driven by a command stream.
// ----------------------------------------------------------------------------
// One command is accepted per clock cycle while s_tready is high and yields
// exactly one result transaction: the command updates the front pointer and
// count and issues its memory read, and for a push its write, in the accept
// cycle; read data and outcome sit in stage s1, and the result waits in the
// output register until taken. s_tready drops only while s1 is full and the
// output register is stalled by m_tready. The element memory is not cleared
// after reset; every live entry has been written by a push before it is read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_list_deque_engine_top #(
	parameter int CAPACITY      = bld_pkg::DEF_CAPACITY,
	parameter int ELEMENT_WIDTH = bld_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bld_pkg::IN_TDATA_W-1:0]  s_tdata,  // value[31:0], position[39:32]
	input  logic [bld_pkg::CMD_W-1:0]       s_tuser,  // cmd[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bld_pkg::OUT_TDATA_W-1:0] m_tdata   // read_data[31:0], length[39:32],
	                                                  // status[41:40], zero[47:42]
);
	import bld_pkg::*;

	localparam int PW    = $clog2(CAPACITY);
	localparam int PAD_W = OUT_TDATA_W - VALUE_W - LEN_W - STATUS_W;

	logic accept, advance;
	logic we, re;
	logic [PW-1:0] waddr, raddr;
	logic [ELEMENT_WIDTH-1:0] wdata, rdata;
	result_t res, res_s1;
	logic s1_valid_q, out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [ELEMENT_WIDTH+VALUE_W-1:0] rd_x;
	logic [VALUE_W-1:0] rd_word;

	// Handshake and stage flow
	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	bld_ctrl #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (s_tuser),
		.value    (s_tdata[VALUE_W-1:0]),
		.position (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (re),
		.raddr    (raddr),
		.res      (res)
	);

	bld_store #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Stage s1 control: fill on accept, empty on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage s1 payload, aligned with the memory read
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Zero the read data unless a read succeeded
	assign rd_x    = {{VALUE_W{1'b0}}, rdata};
	assign rd_word = res_s1.rd_ok ? rd_x[VALUE_W-1:0] : '0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {{PAD_W{1'b0}}, res_s1.status, res_s1.length, rd_word};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Assertions
	`ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_q, "accepted command did not reach s1")
	`ASSERT_IMPLY(a_no_overwrite_s1, s1_valid_q && !advance, !accept,
		"command accepted over a stalled s1 entry")
	`ASSERT_IMPLY(a_rdata_only_ok, m_tvalid && (m_tdata[VALUE_W-1:0] != '0),
		m_tdata[VALUE_W+LEN_W+STATUS_W-1:VALUE_W+LEN_W] == ST_OK,
		"nonzero read data with an error status")

endmodule

### rtl/bld_store.sv
// ----------------------------------------------------------------------------
// bld_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bld_store #(
	parameter int CAPACITY      = bld_pkg::DEF_CAPACITY,
	parameter int ELEMENT_WIDTH = bld_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  logic [ELEMENT_WIDTH-1:0]    wdata,
	input  logic                        re,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output logic [ELEMENT_WIDTH-1:0]    rdata
);
	import bld_pkg::*;

	logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rdata_q;

	// Write the element on a push
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read and hold until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/bld_ctrl.sv
// ----------------------------------------------------------------------------
// bld_ctrl
// Front pointer and count, command decode, and memory access generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bld_ctrl #(
	parameter int CAPACITY      = bld_pkg::DEF_CAPACITY,
	parameter int ELEMENT_WIDTH = bld_pkg::DEF_ELEMENT_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [bld_pkg::CMD_W-1:0]   cmd,
	input  logic [bld_pkg::VALUE_W-1:0] value,
	input  logic [bld_pkg::POS_W-1:0]   position,
	output logic                        we,
	output logic [$clog2(CAPACITY)-1:0] waddr,
	output logic [ELEMENT_WIDTH-1:0]    wdata,
	output logic                        re,
	output logic [$clog2(CAPACITY)-1:0] raddr,
	output bld_pkg::result_t            res
);
	import bld_pkg::*;

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + POS_W;

	logic [PW-1:0] front_q, front_nx, front_dec, front_inc, slot;
	logic [CW-1:0] count_q, count_nx;
	logic [SW-1:0] count_x, pos_x, front_x, cap_x, offset_x, sum_x, slot_x, cnx_x;
	logic [ELEMENT_WIDTH+VALUE_W-1:0] val_x;
	logic full, empty, we_c;
	status_t status_c;
	logic rd_ok_c;

	// Widen operands for compares and slot arithmetic
	assign count_x = SW'(count_q);
	assign pos_x   = SW'(position);
	assign front_x = SW'(front_q);
	assign cap_x   = SW'(CAPACITY);
	assign full    = (count_x >= cap_x);
	assign empty   = (count_q == '0);

	// Slot at head plus offset, wrapped once
	assign offset_x = (cmd_t'(cmd) == CMD_PUSH_BACK) ? count_x : pos_x;
	assign sum_x    = front_x + offset_x;
	assign slot_x   = (sum_x >= cap_x) ? (sum_x - cap_x) : sum_x;
	assign slot     = slot_x[PW-1:0];

	// Neighbor slots of the head
	assign front_dec = (front_q == '0) ? PW'(CAPACITY - 1) : (front_q - 1'b1);
	assign front_inc = (front_q == PW'(CAPACITY - 1)) ? '0 : (front_q + 1'b1);

	// Keep the low element bits of the pushed value
	assign val_x = {{ELEMENT_WIDTH{1'b0}}, value};
	assign wdata = val_x[ELEMENT_WIDTH-1:0];

	// Decode the command
	always_comb begin
		front_nx = front_q;
		count_nx = count_q;
		status_c = ST_OK;
		rd_ok_c  = 1'b0;
		we_c     = 1'b0;
		waddr    = slot;
		unique case (cmd_t'(cmd))
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					front_nx = front_dec;
					waddr    = front_dec;
					we_c     = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					we_c     = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_c = ST_EMPTY;
				end else begin
					front_nx = front_inc;
					count_nx = count_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (pos_x >= count_x) begin
					status_c = ST_RANGE;
				end else begin
					rd_ok_c = 1'b1;
				end
			end
			CMD_TAKE: begin
				if (pos_x < count_x) begin
					count_nx = pos_x[CW-1:0];
				end
			end
			CMD_DROP: begin
				if (pos_x > count_x) begin
					status_c = ST_RANGE;
				end else begin
					front_nx = slot;
					count_nx = count_q - pos_x[CW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Advance pointer and count on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nx;
			count_q <= count_nx;
		end
	end

	// Drive memory and result
	assign we         = accept && we_c;
	assign re         = accept;
	assign raddr      = slot;
	assign cnx_x      = SW'(count_nx);
	assign res.length = cnx_x[LEN_W-1:0];
	assign res.status = status_c;
	assign res.rd_ok  = rd_ok_c;

endmodule
